// ===== hw/rtl/pwsv_pkg.sv =====
`timescale 1ns / 1ps

package pwsv_pkg;

  // Longest varint accepted before the stream is declared malformed.
  localparam int MAX_VARINT_BYTES_DEFAULT = 10;
  // Byte counter inside one varint; holds any limit up to ten and the count that reaches it.
  localparam int VARINT_COUNT_W = 4;

  localparam int FIELD_NUMBER_W = 32;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_FORBIDDEN_FIELD = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_FORBID_ENABLE = 8'd1;

  // Reset values of the configuration registers.
  localparam logic [FIELD_NUMBER_W-1:0] FORBIDDEN_FIELD_RESET = 32'd3;
  localparam logic FORBID_ENABLE_RESET = 1'b1;

  // Verdict codes.
  localparam logic [1:0] VERDICT_PARSING = 2'd0;
  localparam logic [1:0] VERDICT_ACCEPT = 2'd1;
  localparam logic [1:0] VERDICT_REJECT = 2'd2;

  // Reject reason codes.
  localparam logic [2:0] REASON_NONE = 3'd0;
  localparam logic [2:0] REASON_FORBIDDEN = 3'd1;
  localparam logic [2:0] REASON_WIRE_TYPE = 3'd2;
  localparam logic [2:0] REASON_TRUNCATED = 3'd3;
  localparam logic [2:0] REASON_MALFORMED = 3'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_stream;
  } pwsv_in_t;

  typedef struct packed {
    logic [1:0]                verdict;
    logic [2:0]                reject_reason;
    logic                      field_complete;
    logic [FIELD_NUMBER_W-1:0] field_number;
    logic                      last;
  } pwsv_out_t;

  typedef struct packed {
    logic [FIELD_NUMBER_W-1:0] forbidden_field_number;
    logic                      forbid_enable;
  } pwsv_cfg_t;

endpackage

// ===== hw/rtl/pwsv_cfg_regs.sv =====
`timescale 1ns / 1ps

module pwsv_cfg_regs (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pwsv_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [pwsv_pkg::CFG_DATA_W-1:0]    cfg_data,
  output pwsv_pkg::pwsv_cfg_t                cfg
);

  // Every write is taken as soon as it is offered, so the port never pushes back.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.forbidden_field_number <= pwsv_pkg::FORBIDDEN_FIELD_RESET;
      cfg.forbid_enable <= pwsv_pkg::FORBID_ENABLE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pwsv_pkg::CFG_FORBIDDEN_FIELD: begin
          cfg.forbidden_field_number <= cfg_data[pwsv_pkg::FIELD_NUMBER_W-1:0];
        end
        pwsv_pkg::CFG_FORBID_ENABLE: begin
          cfg.forbid_enable <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/pwsv_parser.sv =====
`timescale 1ns / 1ps

module pwsv_parser #(
  parameter int MAX_VARINT_BYTES = pwsv_pkg::MAX_VARINT_BYTES_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  pwsv_pkg::pwsv_in_t   beat,
  input  pwsv_pkg::pwsv_cfg_t  cfg,
  output pwsv_pkg::pwsv_out_t  result
);

  localparam logic [1:0] PH_TAG = 2'd0;
  localparam logic [1:0] PH_VARINT = 2'd1;
  localparam logic [1:0] PH_LENGTH = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;

  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH = 3'd2;
  localparam logic [2:0] WT_FIXED32 = 3'd5;

  localparam int CW = pwsv_pkg::VARINT_COUNT_W;
  localparam logic [CW-1:0] MAX_COUNT = CW'(MAX_VARINT_BYTES);

  typedef struct packed {
    logic [1:0]                          phase;
    logic [63:0]                         acc;
    logic [CW-1:0]                       count;
    logic [63:0]                         skip;
    logic [pwsv_pkg::FIELD_NUMBER_W-1:0] field;
    logic                                rejected;
    logic [2:0]                          reason;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    phase: PH_TAG, acc: 64'd0, count: '0, skip: 64'd0, field: '0,
    rejected: 1'b0, reason: pwsv_pkg::REASON_NONE
  };

  parse_state_t st;
  parse_state_t st_next;

  logic [6:0]  shift;
  logic [63:0] acc_new;
  logic [63:0] skip_dec;
  logic [CW-1:0] count_inc;
  logic [2:0]  wire_type;
  logic        complete;

  always_comb begin
    st_next = st;
    complete = 1'b0;
    shift = 7'(st.count) * 7'd7;
    acc_new = st.acc;
    if (shift < 7'd64) begin
      acc_new = st.acc | ({57'd0, beat.data_byte[6:0]} << shift[5:0]);
    end
    skip_dec = (st.skip != 64'd0) ? (st.skip - 64'd1) : st.skip;
    count_inc = st.count + CW'(1);
    wire_type = acc_new[2:0];

    if (!st.rejected) begin
      if (st.phase == PH_SKIP) begin
        st_next.skip = skip_dec;
        if (skip_dec == 64'd0) begin
          complete = 1'b1;
          st_next.phase = PH_TAG;
        end
      end else begin
        st_next.acc = acc_new;
        st_next.count = count_inc;
        if (beat.data_byte[7]) begin
          if (count_inc >= MAX_COUNT) begin
            st_next.rejected = 1'b1;
            st_next.reason = pwsv_pkg::REASON_MALFORMED;
          end
        end else begin
          st_next.acc = 64'd0;
          st_next.count = '0;
          case (st.phase)
            PH_TAG: begin
              if (acc_new[63:35] != 29'd0) begin
                // Field number wider than 32 bits.
                st_next.field = '1;
                st_next.rejected = 1'b1;
                st_next.reason = pwsv_pkg::REASON_MALFORMED;
              end else begin
                st_next.field = acc_new[34:3];
                if (!(wire_type inside {WT_VARINT, WT_FIXED64, WT_LENGTH, WT_FIXED32})) begin
                  st_next.rejected = 1'b1;
                  st_next.reason = pwsv_pkg::REASON_WIRE_TYPE;
                end else if (cfg.forbid_enable &&
                             acc_new[34:3] == cfg.forbidden_field_number) begin
                  st_next.rejected = 1'b1;
                  st_next.reason = pwsv_pkg::REASON_FORBIDDEN;
                end else begin
                  case (wire_type)
                    WT_VARINT: st_next.phase = PH_VARINT;
                    WT_LENGTH: st_next.phase = PH_LENGTH;
                    WT_FIXED64: begin
                      st_next.phase = PH_SKIP;
                      st_next.skip = 64'd8;
                    end
                    default: begin
                      st_next.phase = PH_SKIP;
                      st_next.skip = 64'd4;
                    end
                  endcase
                end
              end
            end
            PH_VARINT: begin
              complete = 1'b1;
              st_next.phase = PH_TAG;
            end
            default: begin
              if (acc_new == 64'd0) begin
                complete = 1'b1;
                st_next.phase = PH_TAG;
              end else begin
                st_next.skip = acc_new;
                st_next.phase = PH_SKIP;
              end
            end
          endcase
        end
      end
    end

    // A stream that ends in the middle of a field is truncated.
    if (beat.end_of_stream && !st_next.rejected &&
        !(st_next.phase == PH_TAG && st_next.count == '0)) begin
      st_next.rejected = 1'b1;
      st_next.reason = pwsv_pkg::REASON_TRUNCATED;
    end

    if (st_next.rejected) begin
      result.verdict = pwsv_pkg::VERDICT_REJECT;
      result.reject_reason = st_next.reason;
      result.field_complete = 1'b0;
    end else begin
      result.verdict = beat.end_of_stream ? pwsv_pkg::VERDICT_ACCEPT
                                          : pwsv_pkg::VERDICT_PARSING;
      result.reject_reason = pwsv_pkg::REASON_NONE;
      result.field_complete = complete;
    end
    result.field_number = st_next.field;
    result.last = beat.end_of_stream;

    if (beat.end_of_stream) begin
      st_next = STATE_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (step) begin
      st <= st_next;
    end
  end

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    step && beat.end_of_stream |=> st.phase == PH_TAG && st.count == '0 && !st.rejected)
    else $error("parser did not restart after the final byte");

  a_reject_sticky: assert property (@(posedge clk) disable iff (rst)
    st.rejected && !(step && beat.end_of_stream) |=> st.rejected)
    else $error("rejection cleared before the final byte");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    st.count <= MAX_COUNT)
    else $error("varint byte count ran past its limit");

  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    st.phase == PH_SKIP && !st.rejected |-> st.skip != 64'd0)
    else $error("payload skip phase with nothing left to skip");

endmodule

// ===== hw/rtl/protobuf_wire_stream_validator_top.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake             Beat
// in        input      in_valid / in_ready   in_data: one message byte and end flag
// out       output     out_valid / out_ready out_data: verdict for that byte
// cfg       input      cfg_valid / cfg_ready cfg_index, cfg_data: one register write
//
// One byte is taken per cycle while the output is not stalled, and each byte yields
// exactly one result beat. A byte is accepted into the input register and is parsed
// on its way into the output register, which takes its result once it is empty or
// being drained; the parse state update is the single step that sets this rate.
// Reset (rst, synchronous) restores the parse state and the register defaults
// (forbidden field 3, check enabled). When out_ready is low the result holds,
// one more byte may enter the input register, and then in_ready drops.

module protobuf_wire_stream_validator_top #(
  parameter int MAX_VARINT_BYTES = pwsv_pkg::MAX_VARINT_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  pwsv_pkg::pwsv_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output pwsv_pkg::pwsv_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pwsv_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pwsv_pkg::CFG_DATA_W-1:0]  cfg_data
);

  pwsv_pkg::pwsv_cfg_t cfg;
  pwsv_pkg::pwsv_in_t  hold_beat;
  pwsv_pkg::pwsv_out_t step_result;
  logic                hold_valid;
  logic                out_free;
  logic                step;

  // The output register can load when it is empty or being drained this cycle.
  assign out_free = !out_valid || out_ready;
  // The held byte is parsed whenever its result has somewhere to go.
  assign step = hold_valid && out_free;
  assign in_ready = !hold_valid || out_free;

  pwsv_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  pwsv_parser #(
    .MAX_VARINT_BYTES (MAX_VARINT_BYTES)
  ) u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .beat   (hold_beat),
    .cfg    (cfg),
    .result (step_result)
  );

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_beat <= in_data;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= step;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_data <= step_result;
    end
  end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import pwsv_pkg::*;

  // The block is built with its default varint limit, and the predictor uses the same one.
  localparam int unsigned MAX_VARINT = MAX_VARINT_BYTES_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned PHASE_BYTES = 140;
  localparam int unsigned LONG_HOLD = 300;

  // Protobuf wire types. Group start and end are legal in the format, but this block rejects them.
  localparam logic [2:0] WT_VARINT = 3'd0;
  localparam logic [2:0] WT_FIXED64 = 3'd1;
  localparam logic [2:0] WT_LENGTH = 3'd2;
  localparam logic [2:0] WT_GROUP_START = 3'd3;
  localparam logic [2:0] WT_GROUP_END = 3'd4;
  localparam logic [2:0] WT_FIXED32 = 3'd5;
  localparam logic [2:0] WT_RESERVED_6 = 3'd6;
  localparam logic [2:0] WT_RESERVED_7 = 3'd7;

  typedef enum logic [1:0] {WAIT_TAG, WAIT_VARINT, WAIT_LENGTH, SKIP_PAYLOAD} parse_phase_e;

  // Kinds of random message. Every kind except the clean one and the noise one carries a single planted defect.
  typedef enum logic [2:0] {
    MSG_CLEAN, MSG_BAD_WIRE_TYPE, MSG_TRUNCATED, MSG_OVERLONG, MSG_WIDE_FIELD, MSG_NOISE,
    MSG_HUGE_LENGTH
  } msg_kind_e;

  // One directed row. When typed is set, want is the verdict read straight off the spec.
  // When it is clear, the predictor supplies the verdict.
  typedef struct packed {
    pwsv_in_t  beat;
    logic      typed;
    pwsv_out_t want;
  } stim_row_t;

  localparam pwsv_out_t NO_CHECK = '0;

  localparam stim_row_t DIRECTED_ROWS [0:24] = '{
    // A clean message: a varint field, a fixed32 field, and a length field of length zero.
    '{'{8'h08, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h96, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h01, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h0D, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'hFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h80, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h12, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h00, 1'b1}, 1'b1, '{VERDICT_ACCEPT, REASON_NONE, 1'b1, 32'd2, 1'b1}},
    // Field 3 is forbidden after reset. The rejection then holds through the last byte.
    '{'{8'h18, 1'b0}, 1'b1, '{VERDICT_REJECT, REASON_FORBIDDEN, 1'b0, 32'd3, 1'b0}},
    '{'{8'hFF, 1'b1}, 1'b1, '{VERDICT_REJECT, REASON_FORBIDDEN, 1'b0, 32'd3, 1'b1}},
    // Field 3 with a group wire type: the wire type check comes before the forbidden check.
    '{'{8'h1B, 1'b1}, 1'b1, '{VERDICT_REJECT, REASON_WIRE_TYPE, 1'b0, 32'd3, 1'b1}},
    // A fixed64 field that stops after one payload byte.
    '{'{8'h09, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h00, 1'b1}, 1'b1, '{VERDICT_REJECT, REASON_TRUNCATED, 1'b0, 32'd1, 1'b1}},
    // Field number zero with a two-byte varint payload.
    '{'{8'h00, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'hFF, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h7F, 1'b1}, 1'b1, '{VERDICT_ACCEPT, REASON_NONE, 1'b1, 32'd0, 1'b1}},
    // A tag whose field number is 2^32, one past the widest legal field number.
    '{'{8'h80, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h80, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h80, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h80, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h80, 1'b0}, 1'b0, NO_CHECK},
    '{'{8'h01, 1'b1}, 1'b1, '{VERDICT_REJECT, REASON_MALFORMED, 1'b0, 32'hFFFF_FFFF, 1'b1}},
    // The stream ends in the middle of a tag varint.
    '{'{8'h88, 1'b1}, 1'b1, '{VERDICT_REJECT, REASON_TRUNCATED, 1'b0, 32'd0, 1'b1}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  pwsv_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pwsv_out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  protobuf_wire_stream_validator_top #(
    .MAX_VARINT_BYTES(MAX_VARINT)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The predictor's own copy of the parser state and of the two registers.
  parse_phase_e ps_phase;
  logic [63:0] ps_accum;
  int unsigned ps_count;
  logic [63:0] ps_skip;
  logic [31:0] ps_field;
  logic ps_rejected;
  logic [2:0] ps_reason;
  logic [31:0] cfg_forbidden;
  logic cfg_enable;

  pwsv_out_t pending_verdicts[$];
  logic [7:0] msg_bytes[$];
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned send_idle_pct = 19;
  int unsigned recv_idle_pct = 55;
  int unsigned recv_hold = 0;

  function automatic void clear_parse();
    ps_phase = WAIT_TAG;
    ps_accum = '0;
    ps_count = 0;
    ps_skip = '0;
    ps_field = '0;
    ps_rejected = 1'b0;
    ps_reason = REASON_NONE;
  endfunction

  function automatic void flag_reject(input logic [2:0] why);
    ps_rejected = 1'b1;
    ps_reason = why;
  endfunction

  // Advances the predicted parser by one byte and returns the verdict for that byte.
  function automatic pwsv_out_t parse_byte(input pwsv_in_t beat);
    pwsv_out_t res;
    logic done;
    logic [63:0] value;
    logic [2:0] wt;
    done = 1'b0;
    if (!ps_rejected) begin
      if (ps_phase == SKIP_PAYLOAD) begin
        if (ps_skip != 0) ps_skip--;
        if (ps_skip == 0) begin
          done = 1'b1;
          ps_phase = WAIT_TAG;
        end
      end else begin
        // Bits that would land above bit 63 are dropped.
        if (7 * ps_count < 64) ps_accum |= {57'd0, beat.data_byte[6:0]} << (7 * ps_count);
        ps_count++;
        if (beat.data_byte[7]) begin
          if (ps_count >= MAX_VARINT) flag_reject(REASON_MALFORMED);
        end else begin
          value = ps_accum;
          ps_accum = '0;
          ps_count = 0;
          case (ps_phase)
            WAIT_TAG: begin
              wt = value[2:0];
              if (value[63:35] != '0) begin
                ps_field = '1;
                flag_reject(REASON_MALFORMED);
              end else begin
                ps_field = value[34:3];
                if (wt != WT_VARINT && wt != WT_FIXED64 && wt != WT_LENGTH &&
                    wt != WT_FIXED32) begin
                  flag_reject(REASON_WIRE_TYPE);
                end else if (cfg_enable && ps_field == cfg_forbidden) begin
                  flag_reject(REASON_FORBIDDEN);
                end else if (wt == WT_VARINT) begin
                  ps_phase = WAIT_VARINT;
                end else if (wt == WT_LENGTH) begin
                  ps_phase = WAIT_LENGTH;
                end else begin
                  ps_phase = SKIP_PAYLOAD;
                  ps_skip = (wt == WT_FIXED64) ? 64'd8 : 64'd4;
                end
              end
            end
            WAIT_VARINT: begin
              done = 1'b1;
              ps_phase = WAIT_TAG;
            end
            default: begin
              // A zero length completes the field on its own length byte.
              if (value == 0) begin
                done = 1'b1;
                ps_phase = WAIT_TAG;
              end else begin
                ps_skip = value;
                ps_phase = SKIP_PAYLOAD;
              end
            end
          endcase
        end
      end
    end
    if (beat.end_of_stream && !ps_rejected && !(ps_phase == WAIT_TAG && ps_count == 0))
      flag_reject(REASON_TRUNCATED);
    if (ps_rejected) res.verdict = VERDICT_REJECT;
    else res.verdict = beat.end_of_stream ? VERDICT_ACCEPT : VERDICT_PARSING;
    res.reject_reason = ps_rejected ? ps_reason : REASON_NONE;
    res.field_complete = done && !ps_rejected;
    res.field_number = ps_field;
    res.last = beat.end_of_stream;
    if (beat.end_of_stream) clear_parse();
    return res;
  endfunction

  // Offers one beat, holds it until the block takes it, then records the expected verdict.
  task automatic send_byte(input pwsv_in_t beat, input logic typed, input pwsv_out_t want);
    pwsv_out_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do @(posedge clk); while (!in_ready);
    predicted = parse_byte(beat);
    pending_verdicts.push_back(typed ? want : predicted);
  endtask

  // Writes both registers back to back, keeping valid high between the two beats.
  // The enable write carries random upper bits, and only bit 0 of it counts.
  task automatic write_config(input logic [31:0] forbidden, input logic enable);
    for (int i = 0; i < 2; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= (i == 0) ? CFG_FORBIDDEN_FIELD : CFG_FORBID_ENABLE;
      cfg_data <= (i == 0) ? forbidden : {31'($urandom), enable};
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cfg_forbidden = forbidden;
    cfg_enable = enable;
  endtask

  // Mostly small numbers, so that the forbidden one and field zero come up often.
  function automatic logic [31:0] pick_field_number();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 10) return cfg_forbidden;
    if (r < 60) return 32'($urandom_range(15));
    if (r < 75) return 32'($urandom_range(2047));
    if (r < 85) return $urandom;
    if (r < 90) return 32'hFFFF_FFFF;
    return 32'd0;
  endfunction

  function automatic logic [63:0] rand_wide_value();
    return {$urandom, $urandom} >> $urandom_range(63);
  endfunction

  // Appends a varint. A min_len above the minimum gives a padded encoding, as long as ten bytes.
  task automatic append_varint(input logic [63:0] value, input int unsigned min_len);
    logic [63:0] rest;
    int unsigned n;
    rest = value;
    n = 0;
    do begin
      rest >>= 7;
      n++;
    end while (rest != 0);
    if (n < min_len) n = min_len;
    rest = value;
    for (int i = 0; i < n; i++) begin
      msg_bytes.push_back({i < n - 1, rest[6:0]});
      rest >>= 7;
    end
  endtask

  function automatic int unsigned pick_pad();
    return ($urandom_range(99) < 8) ? $urandom_range(2, MAX_VARINT) : 1;
  endfunction

  task automatic append_field();
    logic [2:0] wt;
    int unsigned len;
    case ($urandom_range(3))
      0: wt = WT_VARINT;
      1: wt = WT_FIXED64;
      2: wt = WT_LENGTH;
      default: wt = WT_FIXED32;
    endcase
    append_varint({29'd0, pick_field_number(), wt}, pick_pad());
    case (wt)
      WT_VARINT: append_varint(rand_wide_value(), pick_pad());
      WT_FIXED64: repeat (8) msg_bytes.push_back(8'($urandom));
      WT_FIXED32: repeat (4) msg_bytes.push_back(8'($urandom));
      default: begin
        len = ($urandom_range(99) < 90) ? $urandom_range(12) : $urandom_range(13, 40);
        append_varint(64'(len), pick_pad());
        repeat (len) msg_bytes.push_back(8'($urandom));
      end
    endcase
  endtask

  // Builds one message into msg_bytes. Most messages are well formed; the rest carry a single
  // defect at a random field position, are cut short at the end, or are random noise bytes.
  task automatic build_message();
    msg_kind_e kind;
    int unsigned r;
    int unsigned n_fields;
    int unsigned bad_at;
    logic [63:0] value;
    logic [2:0] bad_wt;
    msg_bytes.delete();
    r = $urandom_range(99);
    if (r < 70) kind = MSG_CLEAN;
    else if (r < 76) kind = MSG_BAD_WIRE_TYPE;
    else if (r < 82) kind = MSG_TRUNCATED;
    else if (r < 87) kind = MSG_OVERLONG;
    else if (r < 91) kind = MSG_WIDE_FIELD;
    else if (r < 95) kind = MSG_NOISE;
    else kind = MSG_HUGE_LENGTH;
    if (kind == MSG_NOISE) begin
      repeat ($urandom_range(1, 12)) msg_bytes.push_back(8'($urandom));
      return;
    end
    n_fields = $urandom_range(1, 4);
    bad_at = $urandom_range(n_fields - 1);
    for (int f = 0; f < n_fields; f++) begin
      if (f != bad_at || kind == MSG_CLEAN || kind == MSG_TRUNCATED) begin
        append_field();
      end else begin
        case (kind)
          MSG_BAD_WIRE_TYPE: begin
            case ($urandom_range(3))
              0: bad_wt = WT_GROUP_START;
              1: bad_wt = WT_GROUP_END;
              2: bad_wt = WT_RESERVED_6;
              default: bad_wt = WT_RESERVED_7;
            endcase
            append_varint({29'd0, pick_field_number(), bad_wt}, pick_pad());
          end
          MSG_OVERLONG: begin
            // An overlong varint, placed either in the tag or in a varint payload.
            if ($urandom_range(1)) append_varint({29'd0, pick_field_number(), WT_VARINT}, 1);
            repeat (MAX_VARINT) msg_bytes.push_back({1'b1, 7'($urandom)});
          end
          MSG_WIDE_FIELD: begin
            value = {$urandom, $urandom};
            value[35 + $urandom_range(28)] = 1'b1;
            append_varint(value, 1);
          end
          default: begin
            // The length outruns any message that is sent, so the stream ends truncated.
            append_varint({29'd0, pick_field_number(), WT_LENGTH}, 1);
            append_varint(rand_wide_value() | 64'h10_0000, 1);
          end
        endcase
        repeat ($urandom_range(3)) msg_bytes.push_back(8'($urandom));
      end
    end
    if (kind == MSG_TRUNCATED && msg_bytes.size() > 1)
      repeat ($urandom_range(1, msg_bytes.size() - 1)) void'(msg_bytes.pop_back());
  endtask

  // Receive side. A beat counts when out_valid and out_ready were both high before the edge.
  // The receiver stalls at random, or for the whole of a long hold that the stimulus asks for.
  always @(posedge clk) begin
    pwsv_out_t want;
    logic bad;
    if (out_valid && out_ready) begin
      if (pending_verdicts.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result beat with no verdict pending: verdict=%0d reason=%0d",
                   $time, out_data.verdict, out_data.reject_reason);
        mismatches++;
      end else begin
        want = pending_verdicts.pop_front();
        bad = (out_data.verdict !== want.verdict) ||
              (out_data.reject_reason !== want.reject_reason) ||
              (out_data.field_complete !== want.field_complete) ||
              (out_data.field_number !== want.field_number) ||
              (out_data.last !== want.last);
        if (bad) begin
          if (mismatches < 10)
            $display("%0t: mismatch verdict=%0d/%0d reason=%0d/%0d complete=%0b/%0b %s%0h/%0h %s%0b/%0b",
                     $time, out_data.verdict, want.verdict, out_data.reject_reason,
                     want.reject_reason, out_data.field_complete, want.field_complete,
                     "field=", out_data.field_number, want.field_number,
                     "last=", out_data.last, want.last);
          mismatches++;
        end
      end
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (recv_hold != 0) begin
      out_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    pwsv_in_t beat;
    int unsigned sent;
    logic [31:0] forbidden;
    logic enable;
    // The predictor starts from the register reset values: field 3, with the check enabled.
    clear_parse();
    cfg_forbidden = 32'd3;
    cfg_enable = 1'b1;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // The directed rows run against the reset register values.
    for (int r = 0; r < $size(DIRECTED_ROWS); r++)
      send_byte(DIRECTED_ROWS[r].beat, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);

    // Random phases. The registers change only once the block has drained, and each phase
    // starts on a message boundary. Idling goes from a slow receiver to a slow sender, and
    // then to none at all.
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: begin forbidden = 32'd0; enable = 1'b1; end
        1: begin forbidden = 32'hFFFF_FFFF; enable = 1'b1; end
        2: begin forbidden = 32'($urandom_range(1, 15)); enable = 1'b0; end
        3: begin forbidden = $urandom; enable = 1'b1; end
        4: begin forbidden = 32'd5; enable = 1'b1; end
        default: begin forbidden = 32'd3; enable = 1'b0; end
      endcase
      send_idle_pct = (p < 2) ? 19 : (p < 4) ? 55 : 0;
      recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 19 : 0;
      write_config(forbidden, enable);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        build_message();
        // Stall the receiver for a long stretch while bytes keep coming. The input side
        // must then back up and drop in_ready.
        if ((p == 1 || p == 4) && sent == 0) recv_hold <= LONG_HOLD;
        foreach (msg_bytes[i]) begin
          beat.data_byte = msg_bytes[i];
          beat.end_of_stream = (i == msg_bytes.size() - 1);
          send_byte(beat, 1'b0, NO_CHECK);
        end
        sent += msg_bytes.size();
      end
      in_valid <= 1'b0;
      do @(posedge clk); while (pending_verdicts.size() != 0);
    end

    // Leave room for any stray beat to show up after the last expected one.
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
